[hdl/bpa_pkg.sv]
// Shared types, codes and defaults of the bitmap page allocator.
package bpa_pkg;

  localparam int MAX_PAGES_DEF = 4096;
  localparam int WORD_BITS_DEF = 32;
  localparam int CFG_W         = 13;
  localparam int INDEX_W       = 12;
  localparam int COUNT_W       = 13;
  localparam logic [CFG_W-1:0] PAGES_RESET = 13'd4096;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [INDEX_W-1:0] page_index;
    logic [COUNT_W-1:0] page_count;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] first_page;
  } result_t;

  // Outcome of one word evaluation by the scan unit.
  typedef struct packed {
    logic found;
    logic in_word;
    logic all_free;
  } hit_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPD_RD,
    S_UPD_WR
  } state_t;

endpackage

[hdl/bpa_map.sv]
// Page bitmap storage: one write port, one read port with registered data.
module bpa_map #(
  parameter int WORDS = 128,
  parameter int WIDTH = 32,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bpa_word_unit.sv]
// Scan unit: evaluates one bitmap word against the run carried in from below.
module bpa_word_unit #(
  parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF,
  parameter int CNT_W     = 14,
  parameter int OFF_W     = 5
) (
  input  logic [WORD_BITS-1:0] used,
  input  logic [CNT_W-1:0]     carry,
  input  logic [CNT_W-1:0]     count,
  output bpa_pkg::hit_t        hit,
  output logic [OFF_W-1:0]     end_bit,
  output logic [CNT_W-1:0]     carry_next
);
  import bpa_pkg::*;

  localparam int BW = $clog2(WORD_BITS + 1);

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [WORD_BITS:0] one;
    one = {{WORD_BITS{1'b0}}, 1'b1};
    return WORD_BITS'((one << n) - one);
  endfunction

  logic [BW-1:0]        tz;
  logic [BW-1:0]        hz;
  logic [CNT_W-1:0]     need;
  logic [CNT_W-1:0]     sel;
  logic [WORD_BITS-1:0] run_mask;
  logic                 found_a;
  logic                 found_b;

  always_comb begin
    tz = '0;
    hz = '0;
    // free pages at the bottom and at the top of the word
    for (int k = 0; k < WORD_BITS; k++) begin
      if ((used & low_mask(CNT_W'(k + 1))) == '0) begin
        tz = BW'(k + 1);
      end
      if ((used & ~low_mask(CNT_W'(WORD_BITS - 1 - k))) == '0) begin
        hz = BW'(k + 1);
      end
    end

    // run continuing from lower words, ending inside this word
    need    = count - carry;
    found_a = (count > carry) && (need <= CNT_W'(tz));

    // run that starts after a used page inside this word; lowest start wins
    run_mask = low_mask(count);
    found_b  = 1'b0;
    sel      = '0;
    for (int s = WORD_BITS - 1; s >= 1; s--) begin
      if ((CNT_W'(s) + count <= CNT_W'(WORD_BITS)) && ((used & (run_mask << s)) == '0)) begin
        found_b = 1'b1;
        sel     = CNT_W'(s);
      end
    end

    hit.found    = found_a || found_b;
    hit.in_word  = !found_a;
    hit.all_free = (tz == BW'(WORD_BITS));
    end_bit      = found_a ? OFF_W'(need - 1'b1) : OFF_W'(sel + count - 1'b1);
    carry_next   = hit.all_free ? carry + CNT_W'(WORD_BITS) : CNT_W'(hz);
  end

endmodule

[hdl/bitmap_page_allocator.sv]
// Bitmap first-fit page allocator: top level with sequencer and update datapath.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+---------------------------------------
//  request  | start, busy, item          | taken at an edge with start=1, busy=0
//  result   | done, result               | valid for one cycle while done=1
//  config   | cfg_we, cfg_wdata          | pages_in_use written when cfg_we=1
//
//  After reset a clearing pass marks every page used, one word a cycle, over all MAP_WORDS
//  words (128 at the defaults); busy stays high meanwhile.
//  Allocate: the scan evaluates the bitmap words in order, one a cycle, up to the end of
//  the first fit; if the run starts at the bottom of a word other than word 0, the update
//  steps past the word below it, then reads and writes each word the run touches. With no
//  fit the scan runs past the last managed word and answers no space. Free: the update
//  steps past each word below the run, then reads and writes each word it touches.
//  Refused items are answered from idle. The result strobe lasts one cycle and cannot stall.
module bitmap_page_allocator #(
  parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
  parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bpa_pkg::item_t             item,
  output logic                       done,
  output bpa_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic [bpa_pkg::CFG_W-1:0]  cfg_wdata
);
  import bpa_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int EW        = AW + 1;
  localparam int PW        = $clog2(MAX_PAGES + 1);
  localparam int CNT_W     = ((PW > COUNT_W) ? PW : COUNT_W) + 1;
  localparam int OFF_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [WORD_BITS:0] one;
    one = {{WORD_BITS{1'b0}}, 1'b1};
    return WORD_BITS'((one << n) - one);
  endfunction

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]     pages_in_use;
  item_t                req;
  logic [AW-1:0]        clr_addr;
  logic [EW-1:0]        scan_addr;
  logic [EW-1:0]        ev_addr;
  logic                 ev_live;
  logic [CNT_W-1:0]     carry;
  logic [EW-1:0]        run_word;
  logic [CNT_W-1:0]     run_wstart;
  logic [CNT_W-1:0]     run_first;
  logic [CNT_W-1:0]     run_end;
  logic [EW-1:0]        upd_addr;
  logic [CNT_W-1:0]     upd_start;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     req_cnt;
  logic [CNT_W-1:0]     item_cnt;
  logic [CNT_W-1:0]     free_end;
  logic                 alloc_refuse;
  logic                 free_refuse;
  logic [CNT_W-1:0]     ev_start;
  logic [CNT_W-1:0]     ev_room;
  logic [CNT_W-1:0]     ev_valid;
  logic [WORD_BITS-1:0] ev_used;
  logic                 scan_end;
  logic                 scan_hit;
  hit_t                 hit;
  logic [OFF_W-1:0]     end_bit;
  logic [CNT_W-1:0]     carry_next;
  logic [CNT_W-1:0]     hit_first;
  logic [CNT_W-1:0]     upd_top;
  logic                 upd_skip;
  logic                 upd_last;
  logic [CNT_W-1:0]     mask_lo;
  logic [CNT_W-1:0]     mask_hi;
  logic [WORD_BITS-1:0] upd_mask;

  logic                 fin;
  status_t              fin_status;
  logic [CNT_W-1:0]     fin_first;

  bpa_map #(
    .WORDS (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bpa_word_unit #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W),
    .OFF_W     (OFF_W)
  ) u_word (
    .used       (ev_used),
    .carry      (carry),
    .count      (req_cnt),
    .hit        (hit),
    .end_bit    (end_bit),
    .carry_next (carry_next)
  );

  always_comb begin
    limit = (CNT_W'(pages_in_use) > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                       : CNT_W'(pages_in_use);
    req_cnt      = CNT_W'(req.page_count);
    item_cnt     = CNT_W'(item.page_count);
    free_end     = CNT_W'(item.page_index) + item_cnt;
    alloc_refuse = (item_cnt == '0) || (item_cnt > limit);
    free_refuse  = (item_cnt == '0) || (free_end > limit);

    // pages at or above the limit count as used
    ev_start = CNT_W'(ev_addr) * CNT_W'(WORD_BITS);
    ev_room  = limit - ev_start;
    ev_valid = (ev_room >= CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : ev_room;
    ev_used  = mem_rdata | ~low_mask(ev_valid);
    scan_end = ev_live && (ev_start >= limit);
    scan_hit = ev_live && !scan_end && hit.found;
    hit_first = ev_start + CNT_W'(end_bit) + CNT_W'(1) - req_cnt;

    upd_top  = upd_start + CNT_W'(WORD_BITS);
    upd_skip = (upd_top <= run_first);
    upd_last = (upd_top >= run_end);
    mask_lo  = (run_first > upd_start) ? run_first - upd_start : '0;
    mask_hi  = upd_last ? run_end - upd_start : CNT_W'(WORD_BITS);
    upd_mask = low_mask(mask_hi) & ~low_mask(mask_lo);
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = upd_addr[AW-1:0];
    mem_wdata  = '0;
    mem_raddr  = scan_addr[AW-1:0];
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_first  = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '1;
        if (clr_addr == AW'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (item.mode == MODE_ALLOC) begin
            if (alloc_refuse) begin
              fin        = 1'b1;
              fin_status = ST_NO_SPACE;
            end else begin
              state_next = S_SCAN;
            end
          end else begin
            if (free_refuse) begin
              fin        = 1'b1;
              fin_status = ST_BAD_RANGE;
            end else begin
              state_next = S_UPD_RD;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          fin        = 1'b1;
          fin_status = ST_NO_SPACE;
          state_next = S_IDLE;
        end else if (scan_hit) begin
          state_next = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        mem_raddr = upd_addr[AW-1:0];
        if (!upd_skip) begin
          state_next = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (req.mode == MODE_ALLOC) ? (mem_rdata | upd_mask)
                                             : (mem_rdata & ~upd_mask);
        if (upd_last) begin
          fin        = 1'b1;
          fin_status = ST_OK;
          fin_first  = (req.mode == MODE_ALLOC) ? run_first : '0;
          state_next = S_IDLE;
        end else begin
          state_next = S_UPD_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= PAGES_RESET;
      clr_addr     <= '0;
      ev_live      <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        pages_in_use <= cfg_wdata;
      end
      done <= fin;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      ev_live <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result.status     <= fin_status;
      result.first_page <= INDEX_W'(fin_first);
    end
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req        <= item;
          carry      <= '0;
          scan_addr  <= '0;
          run_word   <= '0;
          run_wstart <= '0;
          run_first  <= CNT_W'(item.page_index);
          run_end    <= free_end;
          upd_addr   <= '0;
          upd_start  <= '0;
        end
      end
      S_SCAN: begin
        scan_addr <= scan_addr + 1'b1;
        ev_addr   <= scan_addr;
        if (ev_live && !scan_end) begin
          if (hit.found) begin
            run_first <= hit_first;
            run_end   <= hit_first + req_cnt;
            upd_addr  <= hit.in_word ? ev_addr : run_word;
            upd_start <= hit.in_word ? ev_start : run_wstart;
          end else begin
            carry <= carry_next;
            // a used page breaks the run: restart its word mark here
            if (!hit.all_free) begin
              run_word   <= ev_addr;
              run_wstart <= ev_start;
            end
          end
        end
      end
      S_UPD_RD: begin
        if (upd_skip) begin
          upd_addr  <= upd_addr + 1'b1;
          upd_start <= upd_top;
        end
      end
      S_UPD_WR: begin
        upd_addr  <= upd_addr + 1'b1;
        upd_start <= upd_top;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while the sequencer is busy");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK) || (result.first_page == '0))
    else $error("first_page not zero on a refused item");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither started nor answered");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) && (clr_addr == AW'(MAP_WORDS - 1)) |=> !busy)
    else $error("clearing pass did not hand over to idle");

endmodule
